[sv/peer_choke_scheduler_unit_assert.svh]
// Assertion macros for the peer choke scheduler.
`ifndef PEER_CHOKE_SCHEDULER_UNIT_ASSERT_SVH
`define PEER_CHOKE_SCHEDULER_UNIT_ASSERT_SVH

`define PCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pcs_pkg.sv]
// Types and constants shared by the peer choke scheduler modules.
package pcs_pkg;

  localparam logic [1:0] FUNC_STATUS = 2'd0;
  localparam logic [1:0] FUNC_BYTES  = 2'd1;
  localparam logic [1:0] FUNC_ROUND  = 2'd2;

  localparam logic [1:0] KIND_CHOKE   = 2'd0;
  localparam logic [1:0] KIND_UNCHOKE = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  localparam logic [1:0] CFG_UNCHOKE_TOTAL = 2'd0;
  localparam logic [1:0] CFG_OPT_PERIOD    = 2'd1;
  localparam logic [1:0] CFG_NEW_WEIGHT    = 2'd2;

  localparam int RND_BITS = 16;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  slot;
    logic        in_use;
    logic        is_protocol_peer;
    logic        interested;
    logic        joined;
    logic [31:0] amount;
    logic [15:0] random_value;
  } pcs_in_t;

  typedef struct packed {
    logic [3:0] peer_slot;
    logic [1:0] kind;
    logic [3:0] optimistic_slot;
    logic       optimistic_valid;
    logic       last;
  } pcs_res_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_UPDATE,
    OP_PHASE,
    OP_SUM,
    OP_DIV,
    OP_PICK,
    OP_CLRSEL,
    OP_QUOTA,
    OP_MINIT,
    OP_MSCAN,
    OP_MTAKE,
    OP_UNINT,
    OP_MSG,
    OP_DONE
  } pcs_op_e;

  typedef struct packed {
    pcs_op_e op;
    logic    load;
  } pcs_cmd_t;

  typedef struct packed {
    logic draw;
    logic total_zero;
    logic quota_left;
    logic found;
  } pcs_sts_t;

endpackage

[sv/peer_choke_scheduler_unit.sv]
// Top level of the peer choke scheduler.
//
// channel  direction  handshake             beat
// item     in         start high, !busy     pcs_in_t item_i
// result   out        res_valid_o strobe    pcs_res_t res_o
// config   in         cfg_we_i              cfg_idx_i, cfg_data_i
//
// Lottery rounds add a weight sum, a remainder division and a pick; the
// division and the pick are skipped when no protocol peer is in use. Each
// step walks the slot table one entry a cycle, the lottery remainder takes
// one bit a cycle. Reset leaves all slots choking and idle; the receiver
// cannot stall, so each result shows for exactly one cycle.
module peer_choke_scheduler_unit import pcs_pkg::*; #(
  parameter int PEER_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  pcs_in_t    item_i,
  output pcs_res_t   res_o,
  output logic       res_valid_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i
);

  `include "peer_choke_scheduler_unit_assert.svh"

  localparam int IW = $clog2(PEER_SLOTS);

  pcs_cmd_t cmd;
  pcs_sts_t sts;
  logic [IW-1:0] idx;

  pcs_ctrl #(.PEER_SLOTS(PEER_SLOTS)) u_ctrl (
    .clk_i, .rst_ni, .start, .func_i(item_i.func), .sts_i(sts),
    .busy, .cmd_o(cmd), .idx_o(idx)
  );

  pcs_datapath #(.PEER_SLOTS(PEER_SLOTS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .idx_i(idx), .item_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .sts_o(sts), .res_o, .res_valid_o
  );

  `PCS_ASSERT_NOW(a_done_last, res_valid_o, (res_o.kind == KIND_DONE) == res_o.last, "done beat must carry last")
  `PCS_ASSERT_NEXT(a_last_gap, res_valid_o && res_o.last, !res_valid_o, "beat right after last")
  `PCS_ASSERT_NOW(a_opt_zero, res_valid_o && !res_o.optimistic_valid, res_o.optimistic_slot == 4'd0, "optimistic slot without valid")
  `PCS_ASSERT_NEXT(a_round_busy, start && !busy && item_i.func == FUNC_ROUND, busy, "round not started")

endmodule

[sv/pcs_datapath.sv]
// Peer table, lottery divider, max search and result register.
module pcs_datapath import pcs_pkg::*; #(
  parameter int PEER_SLOTS = 16,
  localparam int IW = $clog2(PEER_SLOTS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcs_cmd_t       cmd_i,
  input  logic [IW-1:0]  idx_i,
  input  pcs_in_t        item_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [3:0]     cfg_data_i,
  output pcs_sts_t       sts_o,
  output pcs_res_t       res_o,
  output logic           res_valid_o
);

  localparam int TW = $clog2(3 * PEER_SLOTS + 1);

  logic [3:0] cfg_total_q, cfg_period_q;
  logic [1:0] cfg_weight_q;
  logic [PEER_SLOTS-1:0] use_q, prot_q, int_q, fp_q, sel_q, chk_q;
  logic [31:0] rcv_q [PEER_SLOTS];
  logic [IW-1:0] opt_slot_q;
  logic opt_valid_q;
  logic [3:0] phase_q;
  pcs_in_t itm_q;
  logic [TW-1:0] total_q, rem_q;
  logic [RND_BITS-1:0] rsh_q;
  logic [3:0] quota_q, n_q;
  logic [31:0] thr_q;
  logic thr_none_q, found_q;
  logic [IW-1:0] best_q;
  pcs_res_t res_q;
  logic res_valid_q;

  logic [IW-1:0] uidx, ridx;
  logic [31:0] rx;
  logic [32:0] sum;
  logic [3:0] period, ph, ph_nxt;
  logic [4:0] ph1;
  logic draw;
  logic [1:0] nw, w;
  logic elig;
  logic [TW:0] sh;
  logic [TW-1:0] rem_n;
  logic opt_ok;
  logic [3:0] quota;
  logic cand, better, unint_hit;
  logic [3:0] opt_out;

  assign uidx   = IW'(itm_q.slot);
  assign ridx   = (cmd_i.op == OP_UPDATE) ? uidx : idx_i;
  assign rx     = rcv_q[ridx];
  assign sum    = {1'b0, rx} + {1'b0, itm_q.amount};
  assign period = (cfg_period_q == 4'd0) ? 4'd1 : cfg_period_q;
  assign ph     = (phase_q >= period) ? 4'd0 : phase_q;
  assign draw   = (ph == 4'd0);
  assign ph1    = {1'b0, ph} + 5'd1;
  assign ph_nxt = (ph1 >= {1'b0, period}) ? 4'd0 : ph1[3:0];
  assign nw     = (cfg_weight_q == 2'd0) ? 2'd1 : cfg_weight_q;
  assign elig   = use_q[idx_i] & prot_q[idx_i];
  assign w      = elig ? (fp_q[idx_i] ? nw : 2'd1) : 2'd0;
  assign sh     = {rem_q, rsh_q[RND_BITS-1]};
  assign rem_n  = (sh >= {1'b0, total_q}) ? TW'(sh - {1'b0, total_q}) : TW'(sh);
  assign opt_ok = opt_valid_q & use_q[opt_slot_q] & int_q[opt_slot_q];
  assign quota  = (opt_ok && cfg_total_q == 4'd0) ? 4'd0 : cfg_total_q - {3'd0, opt_ok};
  assign cand   = use_q[idx_i] & ~sel_q[idx_i] & int_q[idx_i];
  assign better = thr_none_q | (rx > thr_q);
  assign unint_hit = use_q[idx_i] & ~int_q[idx_i] & better;
  assign opt_out = opt_valid_q ? 4'(opt_slot_q) : 4'd0;

  assign sts_o.draw       = draw;
  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.quota_left = (n_q < quota_q);
  assign sts_o.found      = found_q;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_total_q  <= 4'd4;
      cfg_period_q <= 4'd3;
      cfg_weight_q <= 2'd3;
      use_q <= '0;
      prot_q <= '0;
      int_q <= '0;
      fp_q <= '0;
      sel_q <= '0;
      chk_q <= '1;
      for (int i = 0; i < PEER_SLOTS; i++) rcv_q[i] <= '0;
      opt_slot_q <= '0;
      opt_valid_q <= 1'b0;
      phase_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_UNCHOKE_TOTAL: cfg_total_q  <= cfg_data_i;
          CFG_OPT_PERIOD:    cfg_period_q <= cfg_data_i;
          CFG_NEW_WEIGHT:    cfg_weight_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) itm_q <= item_i;
      case (cmd_i.op)
        OP_UPDATE: begin
          if (int'(itm_q.slot) < PEER_SLOTS) begin
            if (itm_q.func == FUNC_STATUS) begin
              use_q[uidx]  <= itm_q.in_use;
              prot_q[uidx] <= itm_q.is_protocol_peer;
              int_q[uidx]  <= itm_q.interested;
              if (itm_q.joined) begin
                fp_q[uidx]  <= 1'b1;
                chk_q[uidx] <= 1'b1;
                rcv_q[uidx] <= '0;
              end
            end else if (itm_q.func == FUNC_BYTES) begin
              rcv_q[uidx] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
          end
        end
        OP_PHASE: begin
          phase_q <= ph_nxt;
          rem_q   <= '0;
          rsh_q   <= itm_q.random_value;
          total_q <= '0;
          if (draw) begin
            opt_valid_q <= 1'b0;
            opt_slot_q  <= '0;
          end
        end
        OP_SUM: total_q <= total_q + TW'(w);
        OP_DIV: begin
          rem_q <= rem_n;
          rsh_q <= {rsh_q[RND_BITS-2:0], 1'b0};
        end
        OP_PICK: begin
          if (elig) fp_q[idx_i] <= 1'b0;
          if (!opt_valid_q) begin
            if (rem_q < TW'(w)) begin
              opt_valid_q  <= 1'b1;
              opt_slot_q   <= idx_i;
              sel_q[idx_i] <= 1'b1;
            end else begin
              rem_q <= rem_q - TW'(w);
            end
          end
        end
        OP_CLRSEL: begin
          for (int i = 0; i < PEER_SLOTS; i++) begin
            if (use_q[i] && !(opt_valid_q && opt_slot_q == IW'(i))) sel_q[i] <= 1'b0;
          end
        end
        OP_QUOTA: begin
          quota_q    <= quota;
          n_q        <= '0;
          thr_none_q <= 1'b0;
          thr_q      <= 32'hFFFF_FFFF;
        end
        OP_MINIT: begin
          if (n_q < quota_q) begin
            thr_none_q <= 1'b1;
            found_q    <= 1'b0;
          end
        end
        OP_MSCAN: begin
          if (cand && better) begin
            thr_q      <= rx;
            thr_none_q <= 1'b0;
            best_q     <= idx_i;
            found_q    <= 1'b1;
          end
        end
        OP_MTAKE: begin
          if (found_q) begin
            sel_q[best_q] <= 1'b1;
            n_q <= n_q + 4'd1;
          end
        end
        OP_UNINT: if (unint_hit) sel_q[idx_i] <= 1'b1;
        OP_MSG: begin
          if (use_q[idx_i]) begin
            rcv_q[idx_i] <= '0;
            res_q.peer_slot        <= 4'(idx_i);
            res_q.optimistic_slot  <= opt_out;
            res_q.optimistic_valid <= opt_valid_q;
            res_q.last             <= 1'b0;
            if (sel_q[idx_i] && chk_q[idx_i]) begin
              chk_q[idx_i] <= 1'b0;
              res_q.kind   <= KIND_UNCHOKE;
              res_valid_q  <= 1'b1;
            end else if (!chk_q[idx_i] && !sel_q[idx_i]) begin
              chk_q[idx_i] <= 1'b1;
              res_q.kind   <= KIND_CHOKE;
              res_valid_q  <= 1'b1;
            end
          end
        end
        OP_DONE: begin
          res_q.peer_slot        <= 4'd0;
          res_q.kind             <= KIND_DONE;
          res_q.optimistic_slot  <= opt_out;
          res_q.optimistic_valid <= opt_valid_q;
          res_q.last             <= 1'b1;
          res_valid_q            <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

[sv/pcs_ctrl.sv]
// Update and round sequencer: walks the slot table once per scanning round step.
module pcs_ctrl import pcs_pkg::*; #(
  parameter int PEER_SLOTS = 16,
  localparam int IW = $clog2(PEER_SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic [1:0]    func_i,
  input  pcs_sts_t      sts_i,
  output logic          busy,
  output pcs_cmd_t      cmd_o,
  output logic [IW-1:0] idx_o
);

  localparam int CW = (IW > 4) ? IW : 4;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_PHASE, S_SUM, S_DIV, S_PICK, S_CLRSEL, S_QUOTA,
    S_MINIT, S_MSCAN, S_MTAKE, S_UNINT, S_MSG, S_DONE
  } state_e;

  state_e state_q;
  logic [CW-1:0] cnt_q;
  logic scan_end, div_end, acc;

  assign acc      = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign scan_end = (cnt_q == CW'(PEER_SLOTS - 1));
  assign div_end  = (cnt_q == CW'(RND_BITS - 1));
  assign idx_o    = cnt_q[IW-1:0];

  always_comb begin
    cmd_o.load = acc;
    case (state_q)
      S_UPD:    cmd_o.op = OP_UPDATE;
      S_PHASE:  cmd_o.op = OP_PHASE;
      S_SUM:    cmd_o.op = OP_SUM;
      S_DIV:    cmd_o.op = sts_i.total_zero ? OP_NONE : OP_DIV;
      S_PICK:   cmd_o.op = OP_PICK;
      S_CLRSEL: cmd_o.op = OP_CLRSEL;
      S_QUOTA:  cmd_o.op = OP_QUOTA;
      S_MINIT:  cmd_o.op = OP_MINIT;
      S_MSCAN:  cmd_o.op = OP_MSCAN;
      S_MTAKE:  cmd_o.op = OP_MTAKE;
      S_UNINT:  cmd_o.op = OP_UNINT;
      S_MSG:    cmd_o.op = OP_MSG;
      S_DONE:   cmd_o.op = OP_DONE;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (acc) begin
            if (func_i == FUNC_ROUND) state_q <= S_PHASE;
            else if (func_i == FUNC_STATUS || func_i == FUNC_BYTES) state_q <= S_UPD;
          end
        end
        S_UPD: state_q <= S_IDLE;
        S_PHASE: begin
          cnt_q   <= '0;
          state_q <= sts_i.draw ? S_SUM : S_CLRSEL;
        end
        S_SUM: begin
          cnt_q <= scan_end ? '0 : cnt_q + 1'b1;
          if (scan_end) state_q <= S_DIV;
        end
        S_DIV: begin
          if (sts_i.total_zero) begin
            state_q <= S_CLRSEL;
          end else begin
            cnt_q <= div_end ? '0 : cnt_q + 1'b1;
            if (div_end) state_q <= S_PICK;
          end
        end
        S_PICK: begin
          cnt_q <= scan_end ? '0 : cnt_q + 1'b1;
          if (scan_end) state_q <= S_CLRSEL;
        end
        S_CLRSEL: state_q <= S_QUOTA;
        S_QUOTA:  state_q <= S_MINIT;
        S_MINIT: begin
          cnt_q   <= '0;
          state_q <= sts_i.quota_left ? S_MSCAN : S_UNINT;
        end
        S_MSCAN: begin
          cnt_q <= scan_end ? '0 : cnt_q + 1'b1;
          if (scan_end) state_q <= S_MTAKE;
        end
        S_MTAKE: state_q <= sts_i.found ? S_MINIT : S_UNINT;
        S_UNINT: begin
          cnt_q <= scan_end ? '0 : cnt_q + 1'b1;
          if (scan_end) state_q <= S_MSG;
        end
        S_MSG: begin
          cnt_q <= scan_end ? '0 : cnt_q + 1'b1;
          if (scan_end) state_q <= S_DONE;
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
